// File: hdl/stff_pkg.sv
// ----------------------------------------------------------------------------
// Slice-type frame filter package
// Shared types and constants for the byte-serial slice-type filter.
// ----------------------------------------------------------------------------
package stff_pkg;

   localparam int  DATA_W      = 8;
   localparam int  NAL_W       = 5;
   localparam int  CODE_W      = 8;
   localparam int  CLASS_W     = 2;
   localparam int  RUN_W       = 6;
   localparam int  INDEX_W     = 3;

   localparam logic [DATA_W-1:0]  NAL_MASK       = 8'h1f;
   localparam logic [RUN_W-1:0]   MAX_ZEROS      = 6'd32;
   localparam logic [RUN_W-1:0]   SAT_ZEROS      = 6'd8;
   localparam logic [CODE_W-1:0]  CODE_SAT       = 8'hff;
   localparam logic [INDEX_W-1:0] NAL_BYTE       = 3'd4;
   localparam logic [INDEX_W-1:0] PAYLOAD_BYTE   = 3'd5;
   localparam logic [NAL_W-1:0]   NAL_TYPE_FLUSH = 5'd7;

   // Exp-Golomb parse phases, one-hot.
   typedef enum logic [4:0] {
      PH_PRE1 = 5'b00001,
      PH_SUF1 = 5'b00010,
      PH_PRE2 = 5'b00100,
      PH_SUF2 = 5'b01000,
      PH_DONE = 5'b10000
   } phase_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_I = 2'd0,
      CLASS_P = 2'd1,
      CLASS_B = 2'd2
   } frame_class_type;

   typedef struct packed {
      phase_type          phase;
      logic [RUN_W-1:0]   zero_run;
      logic [RUN_W-1:0]   suffix_left;
      logic [CODE_W-1:0]  code_value;
   } parse_state_type;

   // Header fields of a packet as seen after its last byte.
   typedef struct packed {
      logic [NAL_W-1:0]   nal_type;
      logic [CODE_W-1:0]  slice_type_code;
   } parse_result_type;

endpackage

// File: hdl/stff_if.sv
// ----------------------------------------------------------------------------
// Slice-type frame filter channels
// Valid/ready channels for the byte requests and the per-packet results.
// ----------------------------------------------------------------------------
interface stff_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       is_video;

   modport source (output valid, output data_byte, output last_byte,
                   output is_video, input ready);
   modport sink   (input valid, input data_byte, input last_byte,
                   input is_video, output ready);
endinterface

interface stff_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] nal_type;
   logic [7:0] slice_type_code;
   logic [1:0] frame_class;
   logic       keep_packet;
   logic       flush_queue;

   modport source (output valid, output nal_type, output slice_type_code,
                   output frame_class, output keep_packet, output flush_queue,
                   input ready);
   modport sink   (input valid, input nal_type, input slice_type_code,
                   input frame_class, input keep_packet, input flush_queue,
                   output ready);
endinterface

// File: hdl/stff_parser.sv
// ----------------------------------------------------------------------------
// Slice-type frame filter header parser
// Tracks the byte position, captures the NAL type and steps the two
// Exp-Golomb codes through eight bits per byte.
// ----------------------------------------------------------------------------
module stff_parser
   import stff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [DATA_W-1:0]     data_byte,
   input  logic                  last_byte,
   output parse_result_type      result
);

   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [NAL_W-1:0]   header_type_ff, header_type_in;
   parse_state_type    parse_ff, parse_in;
   parse_state_type    parse_next;

   localparam parse_state_type PARSE_RESET = '{
      phase: PH_PRE1, zero_run: '0, suffix_left: '0, code_value: '0};

   function automatic parse_state_type take_bit(parse_state_type s, logic b,
                                                logic final_bit);
      parse_state_type  r;
      logic             second;
      logic [RUN_W-1:0] left;
      r      = s;
      second = (s.phase == PH_PRE2);
      left   = '0;
      case (s.phase)
         PH_PRE1, PH_PRE2: begin
            if (!b && !final_bit && (s.zero_run < MAX_ZEROS)) begin
               r.zero_run = s.zero_run + 1'b1;
            end else begin
               if (second) begin
                  r.code_value = (s.zero_run >= SAT_ZEROS) ? CODE_SAT :
                                 ((CODE_W'(1) << s.zero_run[2:0]) - CODE_W'(1));
               end
               if (s.zero_run == '0) begin
                  r.phase    = second ? PH_DONE : PH_PRE2;
                  r.zero_run = '0;
               end else begin
                  r.suffix_left = s.zero_run;
                  r.phase       = second ? PH_SUF2 : PH_SUF1;
               end
            end
         end
         PH_SUF1, PH_SUF2: begin
            left          = (s.suffix_left != '0) ? s.suffix_left - 1'b1 : '0;
            r.suffix_left = left;
            // Only codes below saturation collect suffix bits.
            if ((s.phase == PH_SUF2) && (s.zero_run < SAT_ZEROS) && (left < SAT_ZEROS)) begin
               r.code_value = s.code_value + (CODE_W'(b) << left[2:0]);
            end
            if (left == '0) begin
               if (s.phase == PH_SUF1) begin
                  r.phase    = PH_PRE2;
                  r.zero_run = '0;
               end else begin
                  r.phase = PH_DONE;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always_comb begin
      parse_next = parse_ff;
      if (byte_index_ff >= PAYLOAD_BYTE) begin
         for (int k = DATA_W - 1; k >= 0; k--) begin
            parse_next = take_bit(parse_next, data_byte[k], last_byte && (k == 0));
         end
      end
   end

   always_comb begin
      header_type_in = header_type_ff;
      if (byte_index_ff == NAL_BYTE) begin
         header_type_in = NAL_W'(data_byte & NAL_MASK);
      end
   end

   assign result.nal_type        = header_type_in;
   assign result.slice_type_code =
      ((parse_next.phase == PH_SUF2) || (parse_next.phase == PH_DONE)) ?
      parse_next.code_value : '0;

   always_comb begin
      byte_index_in = byte_index_ff;
      parse_in      = parse_ff;
      if (advance) begin
         if (last_byte) begin
            byte_index_in  = '0;
            parse_in       = PARSE_RESET;
         end else begin
            byte_index_in = (byte_index_ff < PAYLOAD_BYTE) ?
                            byte_index_ff + 1'b1 : byte_index_ff;
            parse_in      = parse_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         header_type_ff <= '0;
         parse_ff       <= PARSE_RESET;
      end else begin
         byte_index_ff <= byte_index_in;
         parse_ff      <= parse_in;
         if (advance) begin
            header_type_ff <= last_byte ? '0 : header_type_in;
         end
      end
   end

endmodule

// File: hdl/stff_rsp_stage.sv
// ----------------------------------------------------------------------------
// Slice-type frame filter result stage
// Classifies the slice type, decides keep and flush, and holds the result
// until the sink takes it.
// ----------------------------------------------------------------------------
module stff_rsp_stage
   import stff_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              is_video,
   input  parse_result_type  result,
   output logic              can_load,
   stff_rsp_if.source        rsp_if
);

   logic                 valid_ff, valid_in;
   logic [NAL_W-1:0]     nal_type_ff;
   logic [CODE_W-1:0]    slice_type_ff;
   frame_class_type      class_ff, class_in;
   logic                 keep_ff, keep_in;
   logic                 flush_ff, flush_in;

   always_comb begin
      case (result.slice_type_code)
         8'd1, 8'd6:             class_in = CLASS_B;
         8'd2, 8'd7, 8'd4, 8'd9: class_in = CLASS_I;
         default:                class_in = CLASS_P;
      endcase
      keep_in  = !(is_video && (class_in == CLASS_B));
      flush_in = is_video && keep_in && (result.nal_type == NAL_TYPE_FLUSH);
   end

   assign can_load = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nal_type_ff   <= result.nal_type;
         slice_type_ff <= result.slice_type_code;
         class_ff      <= class_in;
         keep_ff       <= keep_in;
         flush_ff      <= flush_in;
      end
   end

   assign rsp_if.valid           = valid_ff;
   assign rsp_if.nal_type        = nal_type_ff;
   assign rsp_if.slice_type_code = slice_type_ff;
   assign rsp_if.frame_class     = class_ff;
   assign rsp_if.keep_packet     = keep_ff;
   assign rsp_if.flush_queue     = flush_ff;

endmodule

// File: hdl/slice_type_frame_filter_unit.sv
// ----------------------------------------------------------------------------
// Slice-type frame filter
// Reads the NAL type and the Exp-Golomb slice type of each packet and
// decides whether the packet is queued and whether the queue is flushed.
// ----------------------------------------------------------------------------
//  channel   direction  moves
//  req_if    in         one packet byte per request, with last and video flags
//  rsp_if    out        one result per packet, on its last byte
//
// One request is taken every cycle unless a stalled result holds back a last byte;
// a byte waits in the input register and the parser steps all eight of its bits
// as it leaves. A result becomes valid once its last byte has passed from the
// input register into the registered result stage.
// Reset clears the valid flags and the parse position and state.
// A stalled result holds back only a last byte waiting in the input
// register, and the request channel with it; other bytes keep flowing.
// ----------------------------------------------------------------------------
module slice_type_frame_filter_unit
   import stff_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   stff_req_if.sink    req_if,
   stff_rsp_if.source  rsp_if
);

   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              in_video_ff;
   logic              advance;
   logic              can_load;
   logic              req_fire;
   parse_result_type  result;

   assign advance      = in_valid_ff && (!in_last_ff || can_load);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_if.data_byte;
         in_last_ff  <= req_if.last_byte;
         in_video_ff <= req_if.is_video;
      end
   end

   stff_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   stff_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && in_last_ff),
      .is_video (in_video_ff),
      .result   (result),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Slice-type frame filter testbench
// Feeds byte-serial packets through the filter: a few hand-built packets
// first, then random packets built from Exp-Golomb codes with random noise,
// truncation and short packets mixed in. A bit-level model of the slice
// header parser predicts each per-packet result, and every result taken from
// the block is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
   import stff_pkg::*;
();

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 12;
   localparam int ITEM_TARGET  = 1050;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [NAL_W-1:0]  nal_type;
      logic [CODE_W-1:0] slice_type_code;
      frame_class_type   frame_class;
      logic              keep_packet;
      logic              flush_queue;
   } verdict_type;

   typedef enum int {
      RX_OPEN,
      RX_CHOPPY,
      RX_BLOCKED
   } rx_mode_type;

   // Tracks the slice header parse of the packet in flight and holds the
   // verdicts that the block still owes.
   class verdict_board_type;
      logic [INDEX_W-1:0] byte_pos;
      logic [NAL_W-1:0]   nal_hdr;
      phase_type          phase;
      logic [RUN_W-1:0]   run_len;
      logic [RUN_W-1:0]   bits_left;
      logic [8:0]         slice_code;
      verdict_type        verdicts_due[$];
      int unsigned        failures;
      int unsigned        reported;

      function new();
         clear_parse();
         failures = 0;
         reported = 0;
      endfunction

      function void clear_parse();
         byte_pos   = '0;
         nal_hdr    = '0;
         phase      = PH_PRE1;
         run_len    = '0;
         bits_left  = '0;
         slice_code = '0;
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction

      function void close_prefix();
         bit second;
         second = (phase == PH_PRE2);
         if (second) begin
            slice_code = (run_len >= SAT_ZEROS) ? 9'd255 : 9'((1 << run_len) - 1);
         end
         if (run_len == 0) begin
            phase   = second ? PH_DONE : PH_PRE2;
            run_len = '0;
         end else begin
            bits_left = run_len;
            phase     = second ? PH_SUF2 : PH_SUF1;
         end
      endfunction

      function void parse_bit(bit b, bit final_bit);
         case (phase)
            PH_PRE1, PH_PRE2: begin
               if (!b && !final_bit && run_len < MAX_ZEROS) begin
                  run_len++;
               end else begin
                  close_prefix();
               end
            end
            PH_SUF1, PH_SUF2: begin
               if (bits_left > 0) begin
                  bits_left--;
               end
               if (phase == PH_SUF2 && run_len < SAT_ZEROS && bits_left < 8) begin
                  slice_code += 9'(b) << bits_left;
               end
               if (bits_left == 0) begin
                  if (phase == PH_SUF1) begin
                     phase   = PH_PRE2;
                     run_len = '0;
                  end else begin
                     phase = PH_DONE;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void note_request(logic [DATA_W-1:0] data, logic last, logic video);
         verdict_type want;
         logic [CODE_W-1:0] code;
         if (byte_pos == NAL_BYTE) begin
            nal_hdr = data[NAL_W-1:0] & NAL_MASK[NAL_W-1:0];
         end else if (byte_pos >= PAYLOAD_BYTE) begin
            for (int k = DATA_W - 1; k >= 0; k--) begin
               parse_bit(data[k], last && k == 0);
            end
         end
         if (byte_pos < PAYLOAD_BYTE) begin
            byte_pos++;
         end
         if (!last) begin
            return;
         end
         // A slice type exists only once the second code has started.
         code = (phase == PH_SUF2 || phase == PH_DONE) ? slice_code[CODE_W-1:0] : '0;
         case (code)
            8'd1, 8'd6:             want.frame_class = CLASS_B;
            8'd2, 8'd7, 8'd4, 8'd9: want.frame_class = CLASS_I;
            default:                want.frame_class = CLASS_P;
         endcase
         want.nal_type        = nal_hdr;
         want.slice_type_code = code;
         want.keep_packet     = !(video && want.frame_class == CLASS_B);
         want.flush_queue     = video && want.keep_packet && nal_hdr == NAL_TYPE_FLUSH;
         verdicts_due = {verdicts_due, want};
         clear_parse();
      endfunction

      function void check_result(verdict_type got);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            failures++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("ERROR: result with no packet pending: nal %0d code %0d class %0d",
                        got.nal_type, got.slice_type_code, got.frame_class);
            end
            return;
         end
         want = verdicts_due[0];
         verdicts_due.delete(0);
         if (got.nal_type !== want.nal_type ||
             got.slice_type_code !== want.slice_type_code ||
             got.frame_class !== want.frame_class ||
             got.keep_packet !== want.keep_packet ||
             got.flush_queue !== want.flush_queue) begin
            failures++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("ERROR: expected nal %0d code %0d class %0d keep %0d flush %0d",
                        want.nal_type, want.slice_type_code, want.frame_class,
                        want.keep_packet, want.flush_queue);
               $display("       actual   nal %0d code %0d class %0d keep %0d flush %0d",
                        got.nal_type, got.slice_type_code, got.frame_class,
                        got.keep_packet, got.flush_queue);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   stff_req_if req_if ();
   stff_rsp_if rsp_if ();

   slice_type_frame_filter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   verdict_board_type verdicts = new();

   logic [DATA_W-1:0] pkt[$];
   bit                code_bits[$];
   int                sent_count  = 0;
   int                burst_left  = 0;
   int                cycle_count = 0;
   verdict_type       seen;
   logic              pkt_video;

   initial begin
      forever begin
         #CLK_HALF clock = ~clock;
      end
   end

   // Sender: bursts of random length separated by random idle gaps.
   task automatic send_byte(input logic [DATA_W-1:0] data, input logic last,
                            input logic video);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.last_byte <= last;
      req_if.is_video  <= video;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      sent_count++;
      verdicts.note_request(data, last, video);
   endtask

   task automatic send_packet(input logic video);
      for (int i = 0; i < pkt.size(); i++) begin
         send_byte(pkt[i], i == pkt.size() - 1, video);
      end
   endtask

   // Unsigned Exp-Golomb code for a given value.
   function automatic void add_code_value(int unsigned value);
      logic [31:0] x;
      int lead;
      x = value + 1;
      lead = 31;
      while (!x[lead]) begin
         lead--;
      end
      repeat (lead) code_bits = {code_bits, 1'b0};
      for (int i = lead; i >= 0; i--) begin
         code_bits = {code_bits, x[i]};
      end
   endfunction

   // A code with a chosen zero run and a random suffix; long runs reach the
   // cap on counted zeros.
   function automatic void add_raw_code(int prefix);
      repeat (prefix) code_bits = {code_bits, 1'b0};
      code_bits = {code_bits, 1'b1};
      repeat (prefix) code_bits = {code_bits, 1'($urandom_range(0, 1))};
   endfunction

   task automatic build_random_packet(output logic video);
      int kind;
      int n_pay;
      int pick;
      logic [DATA_W-1:0] hdr;
      logic [DATA_W-1:0] b8;
      video = 1'($urandom_range(0, 1));
      kind  = $urandom_range(0, 19);
      pkt.delete();
      code_bits.delete();
      if (kind < 2) begin
         // Packet that ends before or at the header byte.
         repeat ($urandom_range(1, 5)) pkt = {pkt, 8'($urandom)};
         return;
      end
      repeat (4) pkt = {pkt, 8'($urandom)};
      hdr = 8'($urandom);
      if ($urandom_range(0, 2) == 0) begin
         hdr[NAL_W-1:0] = NAL_TYPE_FLUSH;
      end
      pkt = {pkt, hdr};
      if (kind < 4) begin
         // Raw noise as slice data.
         repeat ($urandom_range(0, 6)) pkt = {pkt, 8'($urandom)};
         return;
      end
      if ($urandom_range(0, 9) == 0) begin
         add_raw_code($urandom_range(8, 40));
      end else begin
         add_code_value($urandom_range(0, 20));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         add_code_value($urandom_range(0, 9));
      end else if (pick < 9) begin
         add_code_value($urandom_range(10, 40));
      end else begin
         add_code_value($urandom_range(200, 400));
      end
      repeat ($urandom_range(0, 12)) code_bits = {code_bits, 1'($urandom_range(0, 1))};
      while (code_bits.size() % DATA_W != 0) begin
         code_bits = {code_bits, 1'($urandom_range(0, 1))};
      end
      n_pay = code_bits.size() / DATA_W;
      // Some packets are cut short inside their codes.
      if ($urandom_range(0, 7) == 0) begin
         n_pay = $urandom_range(0, n_pay);
      end
      for (int i = 0; i < n_pay; i++) begin
         for (int j = 0; j < DATA_W; j++) begin
            b8[DATA_W-1-j] = code_bits[DATA_W*i + j];
         end
         pkt = {pkt, b8};
      end
   endtask

   // Receiver: switches between open, choppy and long-stall behavior.
   initial begin
      rx_mode_type rx_mode;
      int stall_left;
      int mode_left;
      rx_mode    = RX_OPEN;
      stall_left = 0;
      mode_left  = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(100, 400);
         end
         mode_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            case (rx_mode)
               RX_CHOPPY: begin
                  if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
               end
               RX_BLOCKED: begin
                  if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 30);
               end
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("slice_type_frame_filter_unit: mismatch");
         $finish;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen.nal_type        = rsp_if.nal_type;
         seen.slice_type_code = rsp_if.slice_type_code;
         seen.frame_class     = frame_class_type'(rsp_if.frame_class);
         seen.keep_packet     = rsp_if.keep_packet;
         seen.flush_queue     = rsp_if.flush_queue;
         verdicts.check_result(seen);
      end
   end

   initial begin
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      req_if.is_video  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One-byte video packet: no header byte, so type and slice type are zero.
      pkt = '{8'h3c};
      send_packet(1'b1);
      // Header only, NAL type 7 with the upper header bits set: kept and flushed.
      pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'he7};
      send_packet(1'b1);
      // First zero run ends on the final bit of the packet.
      pkt = '{8'h00, 8'h00, 8'h01, 8'h65, 8'h05, 8'h00};
      send_packet(1'b1);
      // B slice on a non-video packet is still kept; NAL type 31.
      pkt = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'ha0};
      send_packet(1'b0);
      // A long zero prefix on the slice type saturates; its suffix runs past the end.
      pkt = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h41, 8'h80, 8'h00, 8'hff};
      send_packet(1'b1);

      while (sent_count < ITEM_TARGET) begin
         build_random_packet(pkt_video);
         send_packet(pkt_video);
      end
      @(negedge clock);
      req_if.valid <= 1'b0;

      while (verdicts.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (verdicts.failures == 0) begin
         $display("slice_type_frame_filter_unit: match");
      end else begin
         $display("slice_type_frame_filter_unit: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/stff_pkg.sv
hdl/stff_if.sv
hdl/stff_parser.sv
hdl/stff_rsp_stage.sv
hdl/slice_type_frame_filter_unit.sv
verif/tb_top.sv
